// ----- hw/rtl/lvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared types, constants and helpers of the view matrix core.
// ----------------------------------------------------------------------------
package lvm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IQ_DEPTH      = 2;
    localparam int RQ_DEPTH      = 4;

    localparam logic signed [67:0] MAX32 = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [67:0] MIN32 = 68'shF_FFFF_FFFF_8000_0000;

    // one queued camera request, eye minus target already formed
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
        logic signed [32:0] d_z;
    } t_item;

    // one matrix row result
    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } t_row;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAG,
        S_NORM,
        S_SQ,
        S_SQACC,
        S_SQRT,
        S_DIVI,
        S_DIV,
        S_DIVE,
        S_STORE,
        S_CR,
        S_CRACC,
        S_DOT,
        S_DOTACC,
        S_PUSH
    } t_state;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] c;
        begin
            c = v;
            if (v > MAX32) begin
                c = MAX32;
            end else if (v < MIN32) begin
                c = MIN32;
            end
            return c[31:0];
        end
    endfunction

endpackage

// ----- hw/rtl/lvm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_front
// Input queue: takes camera requests, forms eye minus target, holds them
// for the back-end sequencer.
// ----------------------------------------------------------------------------
module lvm_front
    import lvm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_up_x,
    input  logic signed [31:0] i_up_y,
    input  logic signed [31:0] i_up_z,
    input  logic               i_pop,
    output logic               o_valid,
    output t_item              o_item
);

    localparam int PW = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
    localparam int CW = $clog2(IQ_DEPTH + 1);

    t_item           r_mem [IQ_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    t_item           w_item;
    logic            w_wr;
    logic            w_rd;

    // form the request: exact 33-bit eye minus target
    always_comb begin
        w_item.eye_x = i_eye_x;
        w_item.eye_y = i_eye_y;
        w_item.eye_z = i_eye_z;
        w_item.up_x  = i_up_x;
        w_item.up_y  = i_up_y;
        w_item.up_z  = i_up_z;
        w_item.d_x   = 33'(i_eye_x) - 33'(i_target_x);
        w_item.d_y   = 33'(i_eye_y) - 33'(i_target_y);
        w_item.d_z   = 33'(i_eye_z) - 33'(i_target_z);
    end

    assign o_full  = (r_cnt == CW'(IQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_item  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(IQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(IQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/lvm_resq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_resq
// Result queue: holds finished matrix rows until the consumer takes them.
// ----------------------------------------------------------------------------
module lvm_resq
    import lvm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_row i_row,
    input  logic i_pop,
    output logic o_empty,
    output t_row o_row
);

    localparam int PW = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
    localparam int CW = $clog2(RQ_DEPTH + 1);

    t_row          r_mem [RQ_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CW'(RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_row   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_row;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(RQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(RQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/lvm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_back
// Sequencer that builds the view matrix from one queued request: shared
// multiplier, bit-serial square root and divider, row emission.
// ----------------------------------------------------------------------------
module lvm_back
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_push,
    input  logic  i_full,
    output t_row  o_row
);

    localparam logic [67:0] HALF = 68'(1) << (FRAC_BITS - 1);
    localparam logic [65:0] HI30 = 66'(1) << 30;
    localparam logic [65:0] LO29 = 66'(1) << 29;

    t_state r_state, n_state;

    logic [1:0]         r_phase;
    logic [2:0]         r_k;
    logic [1:0]         r_col;
    logic [1:0]         r_row;
    logic [4:0]         r_cnt;
    logic signed [31:0] r_eye [3];
    logic signed [31:0] r_up  [3];
    logic signed [65:0] r_v   [3];
    logic [65:0]        r_a   [3];
    logic signed [33:0] r_zu  [3];
    logic signed [33:0] r_xu  [3];
    logic signed [33:0] r_yu  [3];
    logic signed [33:0] r_u   [3];
    logic signed [67:0] r_prod;
    logic signed [67:0] r_acc;
    logic [63:0]        r_n;
    logic [63:0]        r_r;
    logic [63:0]        r_b;
    logic [33:0]        r_rem;
    logic [31:0]        r_low;
    logic [31:0]        r_q;

    logic [65:0]        w_m01, w_m, w_ak;
    logic signed [33:0] w_p [3];
    logic signed [33:0] w_q [3];
    logic signed [33:0] w_w [3];
    logic signed [33:0] w_opa, w_opb;
    logic signed [67:0] w_prod;
    logic [63:0]        w_rb;
    logic               w_sq_ge;
    logic [33:0]        w_t;
    logic               w_dv_ge;
    logic [63:0]        w_div;
    logic [67:0]        w_mag, w_rnd;
    logic signed [67:0] w_tr;
    t_row               w_row;

    function automatic logic signed [33:0] sx34(input logic signed [31:0] x);
        return {{2{x[31]}}, x};
    endfunction

    // largest magnitude and operand vectors
    always_comb begin
        w_m01 = (r_a[0] > r_a[1]) ? r_a[0] : r_a[1];
        w_m   = (w_m01 > r_a[2]) ? w_m01 : r_a[2];
        w_ak  = r_a[r_k[1:0]];
        for (int i = 0; i < 3; i++) begin
            w_p[i] = (r_phase == 2'd0) ? sx34(r_up[i]) : r_zu[i];
            w_q[i] = (r_phase == 2'd0) ? r_zu[i] : r_xu[i];
            case (r_row)
                2'd0:    w_w[i] = r_xu[i];
                2'd1:    w_w[i] = r_yu[i];
                default: w_w[i] = r_zu[i];
            endcase
        end
    end

    // shared multiplier operand selection
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (r_state)
            S_SQ: begin
                w_opa = {1'b0, w_ak[32:0]};
                w_opb = {1'b0, w_ak[32:0]};
            end
            S_CR: begin
                case (r_k)
                    3'd0:    begin w_opa = w_p[1]; w_opb = w_q[2]; end
                    3'd1:    begin w_opa = w_p[2]; w_opb = w_q[1]; end
                    3'd2:    begin w_opa = w_p[2]; w_opb = w_q[0]; end
                    3'd3:    begin w_opa = w_p[0]; w_opb = w_q[2]; end
                    3'd4:    begin w_opa = w_p[0]; w_opb = w_q[1]; end
                    default: begin w_opa = w_p[1]; w_opb = w_q[0]; end
                endcase
            end
            S_DOT: begin
                w_opa = w_w[r_col];
                w_opb = sx34(r_eye[r_col]);
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
        w_prod = w_opa * w_opb;
    end

    // root step, divide step, divide setup, translation rounding
    always_comb begin
        w_rb    = r_r + r_b;
        w_sq_ge = (r_n >= w_rb);
        w_t     = {r_rem[32:0], r_low[31]};
        w_dv_ge = (w_t >= r_r[33:0]);
        w_div   = (w_ak[63:0] << FRAC_BITS) + (r_r >> 1);
        w_mag   = r_acc[67] ? 68'(-r_acc) : 68'(r_acc);
        w_rnd   = (w_mag + HALF) >> FRAC_BITS;
        w_tr    = r_acc[67] ? $signed(w_rnd) : -$signed(w_rnd);
    end

    // row being emitted
    always_comb begin
        w_row.row_index = r_row;
        if (r_row == 2'd3) begin
            w_row.col0     = '0;
            w_row.col1     = '0;
            w_row.col2     = '0;
            w_row.col3     = sat32(68'sd1 <<< FRAC_BITS);
            w_row.last_row = 1'b1;
        end else begin
            w_row.col0     = sat32(68'(w_w[0]));
            w_row.col1     = sat32(68'(w_w[1]));
            w_row.col2     = sat32(68'(w_w[2]));
            w_row.col3     = sat32(w_tr);
            w_row.last_row = 1'b0;
        end
    end

    assign o_row  = w_row;
    assign o_pop  = (r_state == S_IDLE) && i_valid;
    assign o_push = (r_state == S_PUSH) && !i_full;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_MAG;
            S_MAG:    n_state = S_NORM;
            S_NORM: begin
                if (w_m == '0) begin
                    n_state = S_STORE;
                end else if (w_m >= LO29 && w_m < HI30) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:     n_state = S_SQACC;
            S_SQACC:  n_state = (r_k == 3'd2) ? S_SQRT : S_SQ;
            S_SQRT:   if (r_cnt == 5'd31) n_state = S_DIVI;
            S_DIVI:   n_state = S_DIV;
            S_DIV:    if (r_cnt == 5'd31) n_state = S_DIVE;
            S_DIVE:   n_state = (r_k == 3'd2) ? S_STORE : S_DIVI;
            S_STORE:  n_state = (r_phase == 2'd2) ? S_DOT : S_CR;
            S_CR:     n_state = S_CRACC;
            S_CRACC:  n_state = (r_k == 3'd5) ? S_MAG : S_CR;
            S_DOT:    n_state = S_DOTACC;
            S_DOTACC: n_state = (r_col == 2'd2) ? S_PUSH : S_DOT;
            S_PUSH: begin
                if (!i_full) begin
                    if (r_row == 2'd3) begin
                        n_state = S_IDLE;
                    end else if (r_row != 2'd2) begin
                        n_state = S_DOT;
                    end
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and sequencing counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_k     <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_cnt   <= '0;
        end else begin
            r_prod <= w_prod;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_eye[0] <= i_item.eye_x;
                        r_eye[1] <= i_item.eye_y;
                        r_eye[2] <= i_item.eye_z;
                        r_up[0]  <= i_item.up_x;
                        r_up[1]  <= i_item.up_y;
                        r_up[2]  <= i_item.up_z;
                        r_v[0]   <= 66'(i_item.d_x);
                        r_v[1]   <= 66'(i_item.d_y);
                        r_v[2]   <= 66'(i_item.d_z);
                        r_phase  <= 2'd0;
                    end
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= r_v[i][65] ? 66'(-r_v[i]) : 66'(r_v[i]);
                    end
                end
                S_NORM: begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (w_m == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_u[i] <= '0;
                        end
                    end else if (w_m >= HI30) begin
                        for (int i = 0; i < 3; i++) begin
                            r_a[i] <= r_a[i] >> 1;
                        end
                    end else if (w_m < LO29) begin
                        for (int i = 0; i < 3; i++) begin
                            r_a[i] <= r_a[i] << 1;
                        end
                    end else begin
                        r_k   <= 3'd0;
                        r_acc <= '0;
                    end
                end
                S_SQACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_k == 3'd2) begin
                        r_n   <= 64'(r_acc + r_prod);
                        r_r   <= '0;
                        r_b   <= 64'(1) << 62;
                        r_cnt <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (w_sq_ge) begin
                        r_n <= r_n - w_rb;
                        r_r <= (r_r >> 1) + r_b;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_b   <= r_b >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_k <= 3'd0;
                    end
                end
                S_DIVI: begin
                    r_rem <= {2'b00, w_div[63:32]};
                    r_low <= w_div[31:0];
                    r_q   <= '0;
                    r_cnt <= '0;
                end
                S_DIV: begin
                    r_rem <= w_dv_ge ? (w_t - r_r[33:0]) : w_t;
                    r_low <= {r_low[30:0], 1'b0};
                    r_q   <= {r_q[30:0], w_dv_ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                S_DIVE: begin
                    r_u[r_k[1:0]] <= r_v[r_k[1:0]][65] ? -$signed({2'b00, r_q})
                                                       : $signed({2'b00, r_q});
                    if (r_k != 3'd2) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_STORE: begin
                    r_k <= 3'd0;
                    case (r_phase)
                        2'd0:    r_zu <= r_u;
                        2'd1:    r_xu <= r_u;
                        default: begin
                            r_yu  <= r_u;
                            r_row <= 2'd0;
                            r_col <= 2'd0;
                            r_acc <= '0;
                        end
                    endcase
                end
                S_CRACC: begin
                    if (!r_k[0]) begin
                        r_v[r_k[2:1]] <= r_prod[65:0];
                    end else begin
                        r_v[r_k[2:1]] <= r_v[r_k[2:1]] - r_prod[65:0];
                    end
                    if (r_k == 3'd5) begin
                        r_phase <= r_phase + 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DOTACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_col != 2'd2) begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (!i_full && r_row != 2'd3) begin
                        r_row <= r_row + 1'b1;
                        r_col <= 2'd0;
                        r_acc <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // checks
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("row transfer into a full result queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MAG) && (r_phase == 2'd0))
        else $error("request transfer did not start a new matrix");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_row.last_row) |=> (r_state == S_IDLE))
        else $error("sequencer busy after the last row");

    a_last_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_row.last_row == (o_row.row_index == 2'd3)))
        else $error("last row flag out of step with row index");

endmodule

// ----- hw/rtl/lookat_view_matrix_core.sv -----
`timescale 1ns / 1ps
// Per request, three normalisations each run a one-bit-a-cycle shift, a 32-step
//   root and three 32-step divisions, all skipped for a zero vector (as when eye
//   equals target). Rows 0 to 2 then each pass the dot-product states before
//   S_PUSH; row 3 follows row 2 from S_PUSH. S_PUSH waits while the result queue
//   is full. A new request is taken only after the last row is pushed.
// Reset: synchronous, active low; both queues empty, sequencer idle.
// ----------------------------------------------------------------------------
// lookat_view_matrix_core
// Camera view matrix from eye, target and up vectors in signed fixed point;
// four row results per request.
// ----------------------------------------------------------------------------
module lookat_view_matrix_core
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_up_x,
    input  logic signed [31:0] i_up_y,
    input  logic signed [31:0] i_up_z,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_last_row
);

    t_item w_item;
    logic  w_valid;
    logic  w_pop;
    logic  w_push;
    logic  w_rq_full;
    t_row  w_row;
    t_row  w_out;

    // request queue
    lvm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_eye_x    (i_eye_x),
        .i_eye_y    (i_eye_y),
        .i_eye_z    (i_eye_z),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_target_z (i_target_z),
        .i_up_x     (i_up_x),
        .i_up_y     (i_up_y),
        .i_up_z     (i_up_z),
        .i_pop      (w_pop),
        .o_valid    (w_valid),
        .o_item     (w_item)
    );

    // matrix sequencer
    lvm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_pop   (w_pop),
        .o_push  (w_push),
        .i_full  (w_rq_full),
        .o_row   (w_row)
    );

    // result queue
    lvm_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_rq_full),
        .i_row   (w_row),
        .i_pop   (pop),
        .o_empty (empty),
        .o_row   (w_out)
    );

    assign o_row_index = w_out.row_index;
    assign o_col0      = w_out.col0;
    assign o_col1      = w_out.col1;
    assign o_col2      = w_out.col2;
    assign o_col3      = w_out.col3;
    assign o_last_row  = w_out.last_row;

endmodule
